### rtl/wstq_pkg.sv
// Package with the constants, codes and types of the work-stealing task queue.
package wstq_pkg;

    // Sizes of the block.
    localparam int HARTS       = 4;
    localparam int QUEUE_DEPTH = 16;

    // Field widths of the command and result items.
    localparam int CMD_W  = 3;
    localparam int HART_W = 2;
    localparam int WORD_W = 64;
    localparam int STAT_W = 3;
    localparam int CNT_W  = 7;
    localparam int WAKE_W = 4;

    // Deque indexing: slots per deque and ring indexes that count modulo twice the depth.
    localparam int SLOT_W = $clog2(QUEUE_DEPTH);
    localparam int IDX_W  = SLOT_W + 1;
    localparam int ADDR_W = HART_W + SLOT_W;
    localparam int SLOTS  = HARTS * QUEUE_DEPTH;

    // A tag holds the owner hart and the stealable flag.
    localparam int TAG_W = HART_W + 1;

    // Saturation value of the pending counters.
    localparam logic [CNT_W-1:0] PEND_MAX = {CNT_W{1'b1}};

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_ISSUE    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_DISPATCH = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP      = 3'd2;
    localparam logic [CMD_W-1:0] CMD_STEAL    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_COMPLETE = 3'd4;
    localparam logic [CMD_W-1:0] CMD_QUERY    = 3'd5;

    // Status codes.
    localparam logic [STAT_W-1:0] ST_DONE    = 3'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY   = 3'd1;
    localparam logic [STAT_W-1:0] ST_FULL    = 3'd2;
    localparam logic [STAT_W-1:0] ST_NOSTEAL = 3'd3;
    localparam logic [STAT_W-1:0] ST_LOCAL   = 3'd4;
    localparam logic [STAT_W-1:0] ST_REJECT  = 3'd5;

    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [ADDR_W-1:0] t_addr;

endpackage

### rtl/work_stealing_task_queue_unit.sv
// Top level of the work-stealing task queue: one ring deque per hart in on-chip memory.
//
// Usage: a command item is taken at a rising edge where start is high and busy is low.
// busy stays low, so one command can be issued in every cycle. Each command gives exactly
// one result item: o_result_valid is high for one cycle and the result fields are valid
// in that cycle only; the receiver cannot hold results back.
// Pipeline: the accepting edge registers the command and reads the task memories at the
// deque end the command touches; the following cycle decides, updates the indexes and
// counters and writes a pushed task, and the result register takes the result and raises
// the result strobe at the edge that ends that cycle.
// Throughput: one command per cycle. The read address of a command is formed from the
// index values that the command ahead of it is writing, and a read of the slot being
// written in the same cycle takes the new data, so back-to-back commands see the same
// state as if they ran one after another.
// Reset: the deque indexes, pending counters, round-robin pointer and valid flags clear.
// The task memories are not cleared; only slots written by a push are ever read out.
module work_stealing_task_queue_unit
    import wstq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [CMD_W-1:0]  i_command,
    input  logic [HART_W-1:0] i_hart,
    input  logic [HART_W-1:0] i_self_hart,
    input  logic [WORD_W-1:0] i_task_function,
    input  logic [WORD_W-1:0] i_task_argument,
    output logic              o_result_valid,
    output logic [STAT_W-1:0] o_status,
    output logic [WORD_W-1:0] o_out_function,
    output logic [WORD_W-1:0] o_out_argument,
    output logic [HART_W-1:0] o_out_owner,
    output logic              o_out_stealable,
    output logic [HART_W-1:0] o_target_hart,
    output logic [CNT_W-1:0]  o_pending_count,
    output logic [WAKE_W-1:0] o_wake_mask
);

    // Task memories.
    logic [WORD_W-1:0] mem_function [SLOTS];
    logic [WORD_W-1:0] mem_argument [SLOTS];
    logic [TAG_W-1:0]  mem_tag      [SLOTS];

    // Per-deque state.
    t_idx              r_top    [HARTS];
    t_idx              r_bottom [HARTS];
    t_cnt              r_pend   [HARTS];
    logic [HART_W-1:0] r_rr;
    t_idx              n_top    [HARTS];
    t_idx              n_bottom [HARTS];
    t_cnt              n_pend   [HARTS];
    logic [HART_W-1:0] n_rr;

    // Command register (first stage).
    logic              r_valid;
    logic [CMD_W-1:0]  r_cmd;
    logic [HART_W-1:0] r_hart;
    logic [HART_W-1:0] r_self;
    logic [WORD_W-1:0] r_fn;
    logic [WORD_W-1:0] r_arg;
    logic [WORD_W-1:0] r_rd_fn;
    logic [WORD_W-1:0] r_rd_arg;
    logic [TAG_W-1:0]  r_rd_tag;

    // Result register (second stage).
    logic              r_res_valid;
    logic [STAT_W-1:0] r_res_status;
    logic [WORD_W-1:0] r_res_fn;
    logic [WORD_W-1:0] r_res_arg;
    logic [HART_W-1:0] r_res_owner;
    logic              r_res_steal;
    logic [HART_W-1:0] r_res_target;
    t_cnt              r_res_pend;
    logic [WAKE_W-1:0] r_res_wake;

    // Second-stage decision signals.
    logic              accept;
    logic              hart_ok;
    logic              fn_nonzero;
    logic [HART_W-1:0] push_hart;
    t_idx              push_occ;
    t_idx              hart_occ;
    logic              push_full;
    logic              push_steal;
    logic              mem_we;
    t_addr             wr_addr;
    t_addr             rd_addr;
    t_idx              rd_idx;
    logic              take_task;
    logic [HART_W-1:0] conc_hart;
    logic [STAT_W-1:0] s_status;
    logic [HART_W-1:0] s_target;
    logic [WAKE_W-1:0] s_wake;
    t_cnt              s_pend;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Read address from the index values that the item ahead is leaving behind.
    always_comb begin
        if (i_command == CMD_POP) begin
            rd_idx = n_bottom[i_hart] - t_idx'(1);
        end else begin
            rd_idx = n_top[i_hart];
        end
        rd_addr = {i_hart, rd_idx[SLOT_W-1:0]};
    end

    // Command register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= accept;
        end
        if (accept) begin
            r_cmd  <= i_command;
            r_hart <= i_hart;
            r_self <= i_self_hart;
            r_fn   <= i_task_function;
            r_arg  <= i_task_argument;
        end
    end

    // Task memories: one write port, one registered read port that takes same-cycle writes.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem_function[wr_addr] <= r_fn;
            mem_argument[wr_addr] <= r_arg;
            mem_tag[wr_addr]      <= {push_hart, push_steal};
        end
        if (mem_we && (wr_addr == rd_addr)) begin
            r_rd_fn  <= r_fn;
            r_rd_arg <= r_arg;
            r_rd_tag <= {push_hart, push_steal};
        end else begin
            r_rd_fn  <= mem_function[rd_addr];
            r_rd_arg <= mem_argument[rd_addr];
            r_rd_tag <= mem_tag[rd_addr];
        end
    end

    // Push target and occupancy checks.
    always_comb begin
        hart_ok    = 32'(r_hart) < HARTS;
        fn_nonzero = (r_fn != '0);
        push_hart  = (r_cmd == CMD_DISPATCH) ? r_rr : r_hart;
        push_occ   = r_bottom[push_hart] - r_top[push_hart];
        push_full  = 32'(push_occ) >= QUEUE_DEPTH;
        hart_occ   = r_bottom[r_hart] - r_top[r_hart];
        wr_addr    = {push_hart, r_bottom[push_hart][SLOT_W-1:0]};
    end

    // Command execution and state update.
    always_comb begin
        n_top      = r_top;
        n_bottom   = r_bottom;
        n_pend     = r_pend;
        n_rr       = r_rr;
        mem_we     = 1'b0;
        push_steal = 1'b0;
        take_task  = 1'b0;
        conc_hart  = r_hart;
        s_status   = ST_REJECT;
        s_target   = '0;
        s_wake     = '0;
        s_pend     = '0;
        if (r_valid) begin
            unique case (r_cmd)
                CMD_ISSUE: begin
                    if (hart_ok && fn_nonzero) begin
                        if (push_full) begin
                            s_status = ST_FULL;
                        end else begin
                            s_status = ST_DONE;
                            mem_we   = 1'b1;
                            s_wake[r_hart] = 1'b1;
                        end
                    end
                end
                CMD_DISPATCH: begin
                    if (fn_nonzero) begin
                        conc_hart = r_rr;
                        s_target  = r_rr;
                        n_rr      = (r_rr == HART_W'(HARTS - 1)) ? '0 : r_rr + HART_W'(1);
                        if (r_rr == r_self) begin
                            s_status = ST_LOCAL;
                        end else if (push_full) begin
                            s_status = ST_FULL;
                        end else begin
                            s_status   = ST_DONE;
                            mem_we     = 1'b1;
                            push_steal = 1'b1;
                            for (int k = 0; k < WAKE_W; k++) begin
                                if (k < HARTS && k != 32'(r_self)) begin
                                    s_wake[k] = 1'b1;
                                end
                            end
                        end
                    end
                end
                CMD_POP: begin
                    if (hart_ok) begin
                        if (hart_occ == '0) begin
                            s_status = ST_EMPTY;
                        end else begin
                            s_status         = ST_DONE;
                            take_task        = 1'b1;
                            n_bottom[r_hart] = r_bottom[r_hart] - t_idx'(1);
                        end
                    end
                end
                CMD_STEAL: begin
                    if (hart_ok) begin
                        if (hart_occ == '0) begin
                            s_status = ST_EMPTY;
                        end else if (!r_rd_tag[0]) begin
                            s_status = ST_NOSTEAL;
                        end else begin
                            s_status      = ST_DONE;
                            take_task     = 1'b1;
                            n_top[r_hart] = r_top[r_hart] + t_idx'(1);
                        end
                    end
                end
                CMD_COMPLETE: begin
                    if (hart_ok) begin
                        if (r_pend[r_hart] == '0) begin
                            s_status = ST_EMPTY;
                        end else begin
                            s_status       = ST_DONE;
                            n_pend[r_hart] = r_pend[r_hart] - t_cnt'(1);
                        end
                    end
                end
                CMD_QUERY: begin
                    if (hart_ok) begin
                        s_status = ST_DONE;
                    end
                end
                default: begin
                    s_status = ST_REJECT;
                end
            endcase

            // A successful push advances the bottom and counts the task as pending, saturating at PEND_MAX.
            if (mem_we) begin
                n_bottom[push_hart] = r_bottom[push_hart] + t_idx'(1);
                if (r_pend[push_hart] != PEND_MAX) begin
                    n_pend[push_hart] = r_pend[push_hart] + t_cnt'(1);
                end
            end

            // Pending count of the concerned owner after the command.
            if (s_status != ST_REJECT) begin
                s_pend = n_pend[conc_hart];
            end
        end
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int h = 0; h < HARTS; h++) begin
                r_top[h]    <= '0;
                r_bottom[h] <= '0;
                r_pend[h]   <= '0;
            end
            r_rr <= '0;
        end else begin
            r_top    <= n_top;
            r_bottom <= n_bottom;
            r_pend   <= n_pend;
            r_rr     <= n_rr;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else begin
            r_res_valid <= r_valid;
        end
        r_res_status <= s_status;
        r_res_target <= s_target;
        r_res_pend   <= s_pend;
        r_res_wake   <= s_wake;
        r_res_fn     <= take_task ? r_rd_fn  : '0;
        r_res_arg    <= take_task ? r_rd_arg : '0;
        r_res_owner  <= take_task ? r_rd_tag[TAG_W-1:1] : '0;
        r_res_steal  <= take_task ? r_rd_tag[0] : 1'b0;
    end

    assign o_result_valid  = r_res_valid;
    assign o_status        = r_res_status;
    assign o_out_function  = r_res_fn;
    assign o_out_argument  = r_res_arg;
    assign o_out_owner     = r_res_owner;
    assign o_out_stealable = r_res_steal;
    assign o_target_hart   = r_res_target;
    assign o_pending_count = r_res_pend;
    assign o_wake_mask     = r_res_wake;

endmodule
